### hw/rtl/apr_pkg.sv
// apr_pkg: shared types, constants and widths for the aging page replacement block
// no dependencies; used by every module under hw/rtl except apr_ram
`default_nettype none

package apr_pkg;

   // field widths
   localparam int PAGE_W      = 16;
   localparam int AGE_W       = 31;
   localparam int TOTAL_W     = 32;
   localparam int FRAMES_W    = 5;
   localparam int SLOT_W      = 4;
   localparam int REQ_DATA_W  = 16;
   localparam int RSP_DATA_W  = 72;

   // default table size
   localparam int MAX_FRAMES_DEF = 16;

   // age given to a frame that holds the referenced page
   localparam logic [AGE_W-1:0] AGE_TOP = 31'h7FFF_FFFF;

   // configuration port
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [0:0] REG_FRAMES_IDX = 1'b0;
   localparam logic [FRAMES_W-1:0] FRAMES_RST = 5'd16;

   // sequencer states
   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_SCAN_WAIT,
      ST_PLACE,
      ST_AGE,
      ST_AGE_WAIT,
      ST_DONE
   } apr_state_type;

   // commands from the sequencer to the datapath
   typedef struct packed {
      logic start;      // latch page and frame count, clear trackers
      logic rd_en;      // read frame at the sweep counter
      logic age_phase;  // current read belongs to the ageing sweep
      logic place;      // install the page in the victim frame on a miss
      logic finish;     // load the result register and update totals
   } apr_cmd_type;

   // status from the datapath to the sequencer
   typedef struct packed {
      logic last_addr;  // sweep counter sits on the last active frame
      logic out_free;   // result register can take a new transaction
   } apr_stat_type;

endpackage

`default_nettype wire

### hw/rtl/apr_ram.sv
// apr_ram: generic simple dual-port ram, one write and one registered read port
// no dependencies
`default_nettype none

module apr_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 16
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### hw/rtl/apr_csr.sv
// apr_csr: apb-style register block holding frames_in_use
// depends on apr_pkg
`default_nettype none

module apr_csr (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_psel,
   input  wire logic                              csr_penable,
   input  wire logic                              csr_pwrite,
   input  wire logic [apr_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  wire logic [apr_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic      [apr_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic                                   csr_pready,
   output logic      [apr_pkg::FRAMES_W-1:0]      frames_in_use
);

   logic [apr_pkg::FRAMES_W-1:0] frames_ff;
   logic [apr_pkg::FRAMES_W-1:0] frames_in;
   logic                         sel_frames;
   logic                         wr_strobe;

   // word index decode
   assign sel_frames = (csr_paddr[apr_pkg::CSR_ADDR_W-1:2] == apr_pkg::REG_FRAMES_IDX);
   assign wr_strobe  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   // register write
   always_comb begin
      frames_in = frames_ff;
      if (wr_strobe && sel_frames) begin
         frames_in = csr_pwdata[apr_pkg::FRAMES_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_ff <= apr_pkg::FRAMES_RST;
      end else begin
         frames_ff <= frames_in;
      end
   end

   // read back
   assign csr_prdata = sel_frames ?
      {{(apr_pkg::CSR_DATA_W-apr_pkg::FRAMES_W){1'b0}}, frames_ff} : '0;
   assign csr_pready    = 1'b1;
   assign frames_in_use = frames_ff;

endmodule

`default_nettype wire

### hw/rtl/apr_ctrl.sv
// apr_ctrl: sequencer for lookup sweep, victim placement and ageing sweep
// depends on apr_pkg
`default_nettype none

module apr_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_tvalid,
   output logic                       req_tready,
   input  wire apr_pkg::apr_stat_type stat,
   output apr_pkg::apr_cmd_type       cmd
);

   apr_pkg::apr_state_type state_ff;
   apr_pkg::apr_state_type state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= apr_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in       = state_ff;
      req_tready     = 1'b0;
      cmd.start      = 1'b0;
      cmd.rd_en      = 1'b0;
      cmd.age_phase  = 1'b0;
      cmd.place      = 1'b0;
      cmd.finish     = 1'b0;
      case (state_ff)
         apr_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.start = 1'b1;
               state_in  = apr_pkg::ST_SCAN;
            end
         end
         apr_pkg::ST_SCAN: begin
            cmd.rd_en = 1'b1;
            if (stat.last_addr) begin
               state_in = apr_pkg::ST_SCAN_WAIT;
            end
         end
         apr_pkg::ST_SCAN_WAIT: begin
            state_in = apr_pkg::ST_PLACE;
         end
         apr_pkg::ST_PLACE: begin
            cmd.place = 1'b1;
            state_in  = apr_pkg::ST_AGE;
         end
         apr_pkg::ST_AGE: begin
            cmd.rd_en     = 1'b1;
            cmd.age_phase = 1'b1;
            if (stat.last_addr) begin
               state_in = apr_pkg::ST_AGE_WAIT;
            end
         end
         apr_pkg::ST_AGE_WAIT: begin
            state_in = apr_pkg::ST_DONE;
         end
         apr_pkg::ST_DONE: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = apr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = apr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

`default_nettype wire

### hw/rtl/apr_datapath.sv
// apr_datapath: frame tables, sweep counter, hit and victim trackers, totals, result register
// depends on apr_pkg and apr_ram
`default_nettype none

module apr_datapath #(
   parameter int MAX_FRAMES = apr_pkg::MAX_FRAMES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic [apr_pkg::PAGE_W-1:0]       req_page,
   input  wire logic [apr_pkg::FRAMES_W-1:0]     frames_in_use,
   input  wire apr_pkg::apr_cmd_type             cmd,
   output apr_pkg::apr_stat_type                 stat,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [apr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                  rsp_tuser
);

   localparam int IDXW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
   localparam int CW   = $clog2(MAX_FRAMES + 1);
   localparam int CMPW = (CW > apr_pkg::FRAMES_W) ? CW : apr_pkg::FRAMES_W;
   localparam int PADW = apr_pkg::RSP_DATA_W - apr_pkg::SLOT_W - 2 * apr_pkg::TOTAL_W;

   // control state
   logic                          rd_vld_ff, rd_vld_in;
   logic [MAX_FRAMES-1:0]         pval_ff, pval_in;
   logic [MAX_FRAMES-1:0]         aval_ff, aval_in;
   logic [apr_pkg::TOTAL_W-1:0]   hit_cnt_ff, hit_cnt_in;
   logic [apr_pkg::TOTAL_W-1:0]   miss_cnt_ff, miss_cnt_in;
   logic                          rsp_valid_ff, rsp_valid_in;

   // payload
   logic [apr_pkg::PAGE_W-1:0]    page_ff, page_in;
   logic [CW-1:0]                 n_ff, n_in;
   logic [IDXW-1:0]               cnt_ff, cnt_in;
   logic                          rd_age_ff, rd_age_in;
   logic [IDXW-1:0]               rd_idx_ff, rd_idx_in;
   logic                          pv_q_ff, pv_q_in;
   logic                          av_q_ff, av_q_in;
   logic                          hit_ff, hit_in;
   logic [IDXW-1:0]               hit_slot_ff, hit_slot_in;
   logic [apr_pkg::AGE_W-1:0]     best_ff, best_in;
   logic [IDXW-1:0]               vic_ff, vic_in;
   logic                          rsp_hit_ff, rsp_hit_in;
   logic [apr_pkg::SLOT_W-1:0]    rsp_slot_ff, rsp_slot_in;

   // ram ports and helpers
   logic [apr_pkg::PAGE_W-1:0]    page_rd;
   logic [apr_pkg::AGE_W-1:0]     age_rd;
   logic [apr_pkg::PAGE_W-1:0]    page_q;
   logic [apr_pkg::AGE_W-1:0]     age_q;
   logic                          page_we;
   logic                          age_we;
   logic [apr_pkg::AGE_W-1:0]     age_new;
   logic [CMPW-1:0]               frames_x;
   logic [CW-1:0]                 n_clamp;
   logic                          page_match;

   apr_ram #(
      .WIDTH (apr_pkg::PAGE_W),
      .DEPTH (MAX_FRAMES)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (page_we),
      .wr_addr (vic_ff),
      .wr_data (page_ff),
      .rd_en   (cmd.rd_en),
      .rd_addr (cnt_ff),
      .rd_data (page_rd)
   );

   apr_ram #(
      .WIDTH (apr_pkg::AGE_W),
      .DEPTH (MAX_FRAMES)
   ) u_age_ram (
      .clock   (clock),
      .wr_en   (age_we),
      .wr_addr (rd_idx_ff),
      .wr_data (age_new),
      .rd_en   (cmd.rd_en),
      .rd_addr (cnt_ff),
      .rd_data (age_rd)
   );

   // entries never written read as zero
   assign page_q     = pv_q_ff ? page_rd : '0;
   assign age_q      = av_q_ff ? age_rd : '0;
   assign page_match = (page_q == page_ff);

   // ageing sweep write back
   assign age_we  = rd_vld_ff & rd_age_ff;
   assign age_new = page_match ? apr_pkg::AGE_TOP : (age_q >> 1);

   // victim install on a miss
   assign page_we = cmd.place & ~hit_ff;

   // clamp frame count to 1..MAX_FRAMES
   assign frames_x = CMPW'(frames_in_use);
   always_comb begin
      if (frames_in_use == '0) begin
         n_clamp = CW'(1);
      end else if (frames_x > CMPW'(MAX_FRAMES)) begin
         n_clamp = CW'(MAX_FRAMES);
      end else begin
         n_clamp = CW'(frames_x);
      end
   end

   // status
   assign stat.last_addr = (CW'(cnt_ff) == (n_ff - CW'(1)));
   assign stat.out_free  = ~rsp_valid_ff | rsp_tready;

   // next-state logic
   always_comb begin
      rd_vld_in    = cmd.rd_en;
      rd_age_in    = cmd.age_phase;
      rd_idx_in    = cnt_ff;
      pval_in      = pval_ff;
      aval_in      = aval_ff;
      hit_cnt_in   = hit_cnt_ff;
      miss_cnt_in  = miss_cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      page_in      = page_ff;
      n_in         = n_ff;
      cnt_in       = cnt_ff;
      pv_q_in      = pv_q_ff;
      av_q_in      = av_q_ff;
      hit_in       = hit_ff;
      hit_slot_in  = hit_slot_ff;
      best_in      = best_ff;
      vic_in       = vic_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_slot_in  = rsp_slot_ff;

      // new transaction
      if (cmd.start) begin
         page_in     = req_page;
         n_in        = n_clamp;
         hit_in      = 1'b0;
         hit_slot_in = '0;
         best_in     = apr_pkg::AGE_TOP;
         vic_in      = '0;
      end

      // sweep counter
      if (cmd.start || cmd.place) begin
         cnt_in = '0;
      end else if (cmd.rd_en) begin
         cnt_in = cnt_ff + IDXW'(1);
      end

      // valid bits travel with the read data
      if (cmd.rd_en) begin
         pv_q_in = pval_ff[cnt_ff];
         av_q_in = aval_ff[cnt_ff];
      end

      // lookup sweep: first match and strict minimum age
      if (rd_vld_ff && !rd_age_ff) begin
         if (!hit_ff && page_match) begin
            hit_in      = 1'b1;
            hit_slot_in = rd_idx_ff;
         end
         if (age_q < best_ff) begin
            best_in = age_q;
            vic_in  = rd_idx_ff;
         end
      end

      if (page_we) begin
         pval_in[vic_ff] = 1'b1;
      end
      if (age_we) begin
         aval_in[rd_idx_ff] = 1'b1;
      end

      // result register and totals
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit_ff;
         rsp_slot_in  = hit_ff ? apr_pkg::SLOT_W'(hit_slot_ff) : apr_pkg::SLOT_W'(vic_ff);
         if (hit_ff) begin
            if (hit_cnt_ff != '1) begin
               hit_cnt_in = hit_cnt_ff + apr_pkg::TOTAL_W'(1);
            end
         end else begin
            if (miss_cnt_ff != '1) begin
               miss_cnt_in = miss_cnt_ff + apr_pkg::TOTAL_W'(1);
            end
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         rd_vld_ff    <= 1'b0;
         pval_ff      <= '0;
         aval_ff      <= '0;
         hit_cnt_ff   <= '0;
         miss_cnt_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rd_vld_ff    <= rd_vld_in;
         pval_ff      <= pval_in;
         aval_ff      <= aval_in;
         hit_cnt_ff   <= hit_cnt_in;
         miss_cnt_ff  <= miss_cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      page_ff     <= page_in;
      n_ff        <= n_in;
      cnt_ff      <= cnt_in;
      rd_age_ff   <= rd_age_in;
      rd_idx_ff   <= rd_idx_in;
      pv_q_ff     <= pv_q_in;
      av_q_ff     <= av_q_in;
      hit_ff      <= hit_in;
      hit_slot_ff <= hit_slot_in;
      best_ff     <= best_in;
      vic_ff      <= vic_in;
      rsp_hit_ff  <= rsp_hit_in;
      rsp_slot_ff <= rsp_slot_in;
   end

   // outputs
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_hit_ff;
   assign rsp_tdata  = {{PADW{1'b0}}, miss_cnt_ff, hit_cnt_ff, rsp_slot_ff};

   // a finished transaction never overwrites a result still waiting
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |-> (!rsp_valid_ff || rsp_tready))
      else $error("result overwritten before it was taken");

   // ageing writes stay inside the active frames
   a_age_in_range: assert property (@(posedge clock) disable iff (reset)
      age_we |-> (CW'(rd_idx_ff) < n_ff))
      else $error("age write outside active frames");

   // victim lies inside the active frames
   a_victim_in_range: assert property (@(posedge clock) disable iff (reset)
      page_we |-> (CW'(vic_ff) < n_ff))
      else $error("victim outside active frames");

   // a hit bumps only the hit total
   a_hit_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.finish && hit_ff && (hit_cnt_ff != '1)) |=>
         ((hit_cnt_ff == $past(hit_cnt_ff) + apr_pkg::TOTAL_W'(1)) &&
          (miss_cnt_ff == $past(miss_cnt_ff))))
      else $error("hit total not advanced correctly");

endmodule

`default_nettype wire

### hw/rtl/aging_page_replacement_top.sv
// aging_page_replacement_top: aging page replacement with apb register block
// depends on apr_pkg, apr_csr, apr_ctrl, apr_datapath (and apr_ram below it)
//
//   group   direction  handshake              payload
//   req_    in         req_tvalid/req_tready  tdata[15:0] page_number
//   rsp_    out        rsp_tvalid/rsp_tready  tuser was_hit; tdata slot, hit_total, miss_total
//   csr_    in/out     psel/penable/pready    frames_in_use at byte address 0
//
// one page reference makes two sweeps over the active frames, a lookup sweep and an ageing sweep,
// each through the single read port of the frame tables
// synchronous active-high reset; tables read as zero until written, no clearing pass
// the next reference is taken while a result waits in the output register;
// a stalled rsp_ side holds the block in its final step only
`default_nettype none

module aging_page_replacement_top #(
   parameter int MAX_FRAMES = apr_pkg::MAX_FRAMES_DEF
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // page_number [15:0]
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   input  wire logic [apr_pkg::REQ_DATA_W-1:0]   req_tdata,
   // slot_index [3:0], hit_total [35:4], miss_total [67:36], zero [71:68]
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   output logic      [apr_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // was_hit [0]
   output logic                                  rsp_tuser,
   input  wire logic                             csr_psel,
   input  wire logic                             csr_penable,
   input  wire logic                             csr_pwrite,
   input  wire logic [apr_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  wire logic [apr_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic      [apr_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                                  csr_pready
);

   logic [apr_pkg::FRAMES_W-1:0] frames_in_use;
   apr_pkg::apr_cmd_type         cmd;
   apr_pkg::apr_stat_type        stat;

   // register block
   apr_csr u_csr (
      .clock         (clock),
      .reset         (reset),
      .csr_psel      (csr_psel),
      .csr_penable   (csr_penable),
      .csr_pwrite    (csr_pwrite),
      .csr_paddr     (csr_paddr),
      .csr_pwdata    (csr_pwdata),
      .csr_prdata    (csr_prdata),
      .csr_pready    (csr_pready),
      .frames_in_use (frames_in_use)
   );

   // sequencer
   apr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   // datapath
   apr_datapath #(
      .MAX_FRAMES (MAX_FRAMES)
   ) u_datapath (
      .clock         (clock),
      .reset         (reset),
      .req_page      (req_tdata[apr_pkg::PAGE_W-1:0]),
      .frames_in_use (frames_in_use),
      .cmd           (cmd),
      .stat          (stat),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .rsp_tdata     (rsp_tdata),
      .rsp_tuser     (rsp_tuser)
   );

endmodule

`default_nettype wire
